// File: sv/afu_pkg.sv
// Shared types, codes and channel constants for the audio feature unit control core.
// No dependencies; imported by every module of the block.
`default_nettype none
package afu_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 32;

  // s_axis tdata: entity, selector, request code, length, data word
  localparam int unsigned IN_DATA_W = 56;
  // fixed m_axis fields below the set count
  localparam int unsigned OUT_FIXED_W = 29;

  localparam logic [7:0] ENT_SPEAKER = 8'h02;
  localparam logic [7:0] ENT_MIC     = 8'h05;
  localparam logic [7:0] ENT_LINE    = 8'h08;

  localparam logic [7:0] CTRL_MUTE   = 8'h01;
  localparam logic [7:0] CTRL_VOLUME = 8'h02;

  localparam logic [7:0] REQ_SET_CUR = 8'h01;
  localparam logic [7:0] REQ_GET_CUR = 8'h81;
  localparam logic [7:0] REQ_GET_MIN = 8'h82;
  localparam logic [7:0] REQ_GET_MAX = 8'h83;
  localparam logic [7:0] REQ_GET_RES = 8'h84;

  localparam logic [1:0] CH_SPK  = 2'd0;
  localparam logic [1:0] CH_MIC  = 2'd1;
  localparam logic [1:0] CH_LINE = 2'd2;

  localparam logic signed [15:0] SPK_MIN = -16'sd25600;
  localparam logic signed [15:0] SPK_MAX = 16'sd0;
  localparam logic signed [15:0] SPK_RES = 16'sd256;
  localparam logic signed [15:0] MIC_MIN = 16'sd0;
  localparam logic signed [15:0] MIC_MAX = 16'sd12288;
  localparam logic signed [15:0] MIC_RES = 16'sd122;

  localparam logic [6:0] PCT_FULL = 7'd100;

  // floor(x / 3) for x <= 300, floor(x / 25) for x < 2^19
  localparam logic [18:0] RECIP3  = 19'd683;
  localparam logic [43:0] RECIP25 = 44'd671089;

  typedef struct packed {
    logic load;
    logic commit;
  } afu_cmd_t;

  function automatic logic [1:0] chan_of(input logic [7:0] ent);
    logic [1:0] ch;
    ch = CH_MIC;
    if (ent == ENT_SPEAKER) ch = CH_SPK;
    if (ent == ENT_LINE) ch = CH_LINE;
    return ch;
  endfunction

  function automatic logic is_known(input logic [7:0] ent);
    return (ent == ENT_SPEAKER) || (ent == ENT_MIC) || (ent == ENT_LINE);
  endfunction

  function automatic logic signed [15:0] range_min(input logic [1:0] ch);
    return (ch == CH_SPK) ? SPK_MIN : MIC_MIN;
  endfunction

  function automatic logic signed [15:0] range_max(input logic [1:0] ch);
    return (ch == CH_SPK) ? SPK_MAX : MIC_MAX;
  endfunction

  function automatic logic signed [15:0] range_res(input logic [1:0] ch);
    return (ch == CH_SPK) ? SPK_RES : MIC_RES;
  endfunction

endpackage
`default_nettype wire

// File: sv/afu_controller.sv
// Handshake sequencer for the audio feature unit control core.
// Depends on afu_pkg for the command struct.
`default_nettype none
module afu_controller
  import afu_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid_i,
  output logic      s_axis_tready_o,
  output logic      m_axis_tvalid_o,
  input  wire logic m_axis_tready_i,
  output afu_cmd_t  cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q;
    cmd_o.load   = 1'b0;
    cmd_o.commit = 1'b0;
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid_q || m_axis_tready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;

endmodule
`default_nettype wire

// File: sv/afu_datapath.sv
// Channel state, volume arithmetic and result register of the feature unit core.
// Depends on afu_pkg for codes, channel ranges and reciprocal constants.
`default_nettype none
module afu_datapath
  import afu_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int unsigned OUT_W       = ((OUT_FIXED_W + COUNT_WIDTH + 7) / 8) * 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire afu_cmd_t             cmd_i,
  input  wire logic                 s_axis_tuser_i,
  input  wire logic [IN_DATA_W-1:0] s_axis_tdata_i,
  output logic      [OUT_W-1:0]     m_axis_tdata_o
);

  // channel state
  logic                   mute_q [3];
  logic [6:0]             pct_q  [3];
  logic [COUNT_WIDTH-1:0] cnt_q  [3];

  // request registers
  logic        cmd_q;
  logic [7:0]  ent_q, ctl_q, req_q;
  logic [15:0] len_q, data_q;
  logic [18:0] prod1_q, prod1_d;
  logic [6:0]  pct_spk_q, pct_spk_d;
  logic signed [15:0] units_spk_q, units_spk_d;
  logic [OUT_W-1:0]   tdata_q, tdata_d;

  // first step: operand selection, clamp and first product
  logic [7:0]         ent_in;
  logic [1:0]         ch_in;
  logic [6:0]         pct_in, pc;
  logic signed [15:0] din, uc, spk_off;

  always_comb begin
    ent_in = s_axis_tdata_i[7:0];
    ch_in  = chan_of(ent_in);
    if (ch_in == CH_SPK) pct_in = pct_q[0];
    else if (ch_in == CH_LINE) pct_in = pct_q[2];
    else pct_in = pct_q[1];
    pc  = (pct_in > PCT_FULL) ? PCT_FULL : pct_in;
    din = $signed(s_axis_tdata_i[55:40]);
    uc  = din;
    if (din < range_min(ch_in)) uc = range_min(ch_in);
    if (din > range_max(ch_in)) uc = range_max(ch_in);
    spk_off     = uc - SPK_MIN;
    pct_spk_d   = spk_off[14:8];
    units_spk_d = SPK_MIN + $signed({1'b0, pc, 8'b0});
    if (s_axis_tuser_i) begin
      prod1_d = 19'(pc) * 19'd3072;
    end else begin
      prod1_d = 19'(uc[13:0]) * 19'd25;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q       <= s_axis_tuser_i;
      ent_q       <= s_axis_tdata_i[7:0];
      ctl_q       <= s_axis_tdata_i[15:8];
      req_q       <= s_axis_tdata_i[23:16];
      len_q       <= s_axis_tdata_i[39:24];
      data_q      <= s_axis_tdata_i[55:40];
      prod1_q     <= prod1_d;
      pct_spk_q   <= pct_spk_d;
      units_spk_q <= units_spk_d;
    end
  end

  // second step: reciprocal divide, decode and state update
  logic [18:0]            q3;
  logic [43:0]            prod2;
  logic [6:0]             pct_mic;
  logic [15:0]            units_mic;
  logic [1:0]             ch;
  logic                   known, ok;
  logic [15:0]            rdata;
  logic [1:0]             rlen;
  logic                   mute_cur, mute_new, mute_we;
  logic [6:0]             pct_cur, pct_new;
  logic [COUNT_WIDTH-1:0] cnt_cur, cnt_new;
  logic                   vol_we;

  always_comb begin
    q3        = 19'(prod1_q[18:10]) * RECIP3;
    pct_mic   = q3[17:11];
    prod2     = 44'(prod1_q) * RECIP25;
    units_mic = prod2[39:24];
    ch        = chan_of(ent_q);
    known     = is_known(ent_q);
    if (ch == CH_SPK) begin
      mute_cur = mute_q[0];
      pct_cur  = pct_q[0];
      cnt_cur  = cnt_q[0];
    end else if (ch == CH_LINE) begin
      mute_cur = mute_q[2];
      pct_cur  = pct_q[2];
      cnt_cur  = cnt_q[2];
    end else begin
      mute_cur = mute_q[1];
      pct_cur  = pct_q[1];
      cnt_cur  = cnt_q[1];
    end
    ok       = 1'b0;
    rdata    = '0;
    rlen     = 2'd0;
    mute_we  = 1'b0;
    vol_we   = 1'b0;
    mute_new = mute_cur;
    pct_new  = pct_cur;
    cnt_new  = cnt_cur;
    if (known && !cmd_q) begin
      if (ctl_q == CTRL_MUTE && req_q == REQ_SET_CUR && len_q == 16'd1) begin
        ok       = 1'b1;
        mute_we  = 1'b1;
        mute_new = (data_q[7:0] != 8'd0);
      end else if (ctl_q == CTRL_VOLUME && req_q == REQ_SET_CUR && len_q == 16'd2) begin
        ok      = 1'b1;
        vol_we  = 1'b1;
        pct_new = (ch == CH_SPK) ? pct_spk_q : pct_mic;
        cnt_new = cnt_cur + COUNT_WIDTH'(1);
      end
    end else if (known) begin
      if (ctl_q == CTRL_MUTE) begin
        ok    = 1'b1;
        rdata = 16'(mute_cur);
        rlen  = 2'd1;
      end else if (ctl_q == CTRL_VOLUME) begin
        ok   = 1'b1;
        rlen = 2'd2;
        case (req_q)
          REQ_GET_CUR: rdata = (ch == CH_SPK) ? units_spk_q : units_mic;
          REQ_GET_MIN: rdata = range_min(ch);
          REQ_GET_MAX: rdata = range_max(ch);
          REQ_GET_RES: rdata = range_res(ch);
          default: begin
            ok   = 1'b0;
            rlen = 2'd0;
          end
        endcase
      end
    end
    tdata_d                          = '0;
    tdata_d[0]                       = ok;
    tdata_d[16:1]                    = rdata;
    tdata_d[18:17]                   = rlen;
    tdata_d[20:19]                   = ch;
    tdata_d[27:21]                   = pct_new;
    tdata_d[28]                      = mute_new;
    tdata_d[OUT_FIXED_W +: COUNT_WIDTH] = cnt_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        mute_q[i] <= 1'b0;
        pct_q[i]  <= PCT_FULL;
        cnt_q[i]  <= '0;
      end
    end else if (cmd_i.commit) begin
      for (int i = 0; i < 3; i++) begin
        if (ch == 2'(i)) begin
          if (mute_we) mute_q[i] <= mute_new;
          if (vol_we) begin
            pct_q[i] <= pct_new;
            cnt_q[i] <= cnt_new;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      tdata_q <= tdata_d;
    end
  end

  assign m_axis_tdata_o = tdata_q;

endmodule
`default_nettype wire

// File: sv/audio_feature_unit_control_core.sv
// Request registers capture a request at its input transfer; the result register
// loads on commit in S_EXEC. New requests are taken only in S_IDLE, after commit,
// for the two-step volume divide (clamp and first product, then reciprocal multiply).
// One request is taken while a result is held on m_axis; its result waits until then.
// Reset: asynchronous, active low; mute 0, percent 100, set counts 0 per channel.
// Top level; depends on afu_pkg, afu_controller and afu_datapath.
`default_nettype none
module audio_feature_unit_control_core
  import afu_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int unsigned OUT_W       = ((OUT_FIXED_W + COUNT_WIDTH + 7) / 8) * 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // entity_id, control_selector, request_code, request_length, data_word
  input  wire logic [IN_DATA_W-1:0] s_axis_tdata_i,
  // cmd
  input  wire logic                 s_axis_tuser_i,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // accepted, reply_data, reply_length, channel_index, channel_percent,
  // channel_mute, channel_set_count, zero padding
  output logic      [OUT_W-1:0]     m_axis_tdata_o
);

  afu_cmd_t cmd;

  afu_controller u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cmd_o           (cmd)
  );

  afu_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .OUT_W       (OUT_W)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for audio_feature_unit_control_core: directed and random
// feature-unit requests with a scoreboard predicting every reply. Depends on afu_pkg.
`timescale 1ns / 1ps

module testbench;
  import afu_pkg::*;

  localparam int OUT_W = ((OUT_FIXED_W + COUNT_WIDTH_DEF + 7) / 8) * 8;

  typedef struct {
    logic        accepted;
    logic [15:0] reply_data;
    logic [1:0]  reply_length;
    logic [1:0]  channel_index;
    logic [6:0]  channel_percent;
    logic        channel_mute;
    logic [31:0] channel_set_count;
  } fu_reply_t;

  class fu_reply_tracker;
    bit          mute_q [3];
    bit   [6:0]  pct_q [3];
    bit   [31:0] set_cnt_q [3];
    int          vol_lo [3];
    int          vol_hi [3];
    int          vol_res [3];
    fu_reply_t   pending_replies [$];
    int          errors;
    int          handled;
    int          stalled;

    function new();
      vol_lo  = '{-100 * 256, 0, 0};
      vol_hi  = '{0, 48 * 256, 48 * 256};
      vol_res = '{256, 'h7a, 'h7a};
      foreach (mute_q[i]) begin
        mute_q[i]    = 1'b0;
        pct_q[i]     = PCT_FULL;
        set_cnt_q[i] = '0;
      end
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction

    function void log_request(bit is_get, logic [IN_DATA_W-1:0] d);
      logic [7:0]  ent;
      logic [7:0]  ctl;
      logic [7:0]  req;
      logic [15:0] len;
      logic [15:0] word;
      int          ch;
      int          units;
      bit          known;
      fu_reply_t   r;
      ent   = d[7:0];
      ctl   = d[15:8];
      req   = d[23:16];
      len   = d[39:24];
      word  = d[55:40];
      ch    = int'((ent == ENT_SPEAKER) ? CH_SPK : (ent == ENT_LINE) ? CH_LINE : CH_MIC);
      known = (ent == ENT_SPEAKER) || (ent == ENT_MIC) || (ent == ENT_LINE);
      r.accepted     = 1'b0;
      r.reply_data   = '0;
      r.reply_length = '0;
      if (known && !is_get) begin
        if (ctl == CTRL_MUTE && req == REQ_SET_CUR && len == 16'd1) begin
          mute_q[ch] = (word[7:0] != 8'd0);
          r.accepted = 1'b1;
        end else if (ctl == CTRL_VOLUME && req == REQ_SET_CUR && len == 16'd2) begin
          units = int'($signed(word));
          if (units < vol_lo[ch]) units = vol_lo[ch];
          if (units > vol_hi[ch]) units = vol_hi[ch];
          pct_q[ch]     = 7'(((units - vol_lo[ch]) * 100) / (vol_hi[ch] - vol_lo[ch]));
          set_cnt_q[ch] = set_cnt_q[ch] + 1;
          r.accepted    = 1'b1;
        end
      end else if (known) begin
        if (ctl == CTRL_MUTE) begin
          r.accepted     = 1'b1;
          r.reply_data   = 16'(mute_q[ch]);
          r.reply_length = 2'd1;
        end else if (ctl == CTRL_VOLUME) begin
          r.accepted = 1'b1;
          case (req)
            REQ_GET_CUR: units = vol_lo[ch]
                               + ((vol_hi[ch] - vol_lo[ch]) * int'(pct_q[ch])) / 100;
            REQ_GET_MIN: units = vol_lo[ch];
            REQ_GET_MAX: units = vol_hi[ch];
            REQ_GET_RES: units = vol_res[ch];
            default: r.accepted = 1'b0;
          endcase
          if (r.accepted) begin
            r.reply_data   = 16'(units);
            r.reply_length = 2'd2;
          end
        end
      end
      r.channel_index     = 2'(ch);
      r.channel_percent   = pct_q[ch];
      r.channel_mute      = mute_q[ch];
      r.channel_set_count = set_cnt_q[ch];
      pending_replies.push_back(r);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_reply(logic [OUT_W-1:0] t);
      fu_reply_t w;
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0t: reply with none expected, expected none, actual %0h", $time, t);
        return;
      end
      w = pending_replies.pop_front();
      if (w.accepted) handled++;
      else stalled++;
      compare("accepted", 32'(w.accepted), 32'(t[0]));
      compare("reply_data", 32'(w.reply_data), 32'(t[16:1]));
      compare("reply_length", 32'(w.reply_length), 32'(t[18:17]));
      compare("channel_index", 32'(w.channel_index), 32'(t[20:19]));
      compare("channel_percent", 32'(w.channel_percent), 32'(t[27:21]));
      compare("channel_mute", 32'(w.channel_mute), 32'(t[28]));
      compare("channel_set_count", w.channel_set_count, t[60:29]);
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_valid = 1'b0;
  logic                 s_ready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_valid;
  logic                 m_ready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  fu_reply_tracker tracker = new();

  audio_feature_unit_control_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) tracker.check_reply(m_tdata);
    m_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_request(input bit is_get, input logic [7:0] ent, input logic [7:0] ctl,
                              input logic [7:0] req, input logic [15:0] len,
                              input logic [15:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_tuser <= is_get;
    s_tdata <= {word, len, req, ctl, ent};
    do @(posedge clk_i); while (!s_ready);
    tracker.log_request(is_get, {word, len, req, ctl, ent});
  endtask

  task automatic send_random();
    logic [7:0]  ent;
    logic [7:0]  ctl;
    logic [7:0]  req;
    logic [15:0] len;
    logic [15:0] word;
    bit          is_get;
    int          pick;
    pick = $urandom_range(2);
    ent  = (pick == 0) ? ENT_SPEAKER : (pick == 1) ? ENT_MIC : ENT_LINE;
    word = 16'($urandom);
    if ($urandom_range(99) < 80) begin
      case ($urandom_range(5))
        0: begin
          is_get = 1'b0; ctl = CTRL_MUTE; req = REQ_SET_CUR; len = 16'd1;
          if ($urandom_range(1)) word[7:0] = 8'd0;
        end
        1, 2: begin
          is_get = 1'b0; ctl = CTRL_VOLUME; req = REQ_SET_CUR; len = 16'd2;
          if ($urandom_range(3) != 0)
            word = (ent == ENT_SPEAKER) ? 16'(-$urandom_range(25600))
                                        : 16'($urandom_range(12288));
        end
        3: begin
          is_get = 1'b1; ctl = CTRL_MUTE; req = 8'($urandom); len = 16'($urandom);
        end
        default: begin
          is_get = 1'b1; ctl = CTRL_VOLUME; len = 16'd2;
          req = 8'($urandom_range(REQ_GET_CUR, REQ_GET_RES));
        end
      endcase
    end else begin
      is_get = 1'($urandom_range(1));
      if ($urandom_range(1)) ent = 8'($urandom);
      ctl = $urandom_range(1) ? 8'($urandom_range(CTRL_MUTE, CTRL_VOLUME)) : 8'($urandom);
      req = $urandom_range(1) ? REQ_SET_CUR : 8'($urandom);
      len = $urandom_range(1) ? 16'($urandom_range(3)) : 16'($urandom);
    end
    send_request(is_get, ent, ctl, req, len, word);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 21;
    recv_idle_pct = 76;
    send_request(1'b1, ENT_SPEAKER, CTRL_VOLUME, REQ_GET_CUR, 16'd2, 16'h0000);
    send_request(1'b1, ENT_SPEAKER, CTRL_VOLUME, REQ_GET_MIN, 16'd2, 16'h0000);
    send_request(1'b1, ENT_SPEAKER, CTRL_VOLUME, REQ_GET_MAX, 16'd2, 16'hffff);
    send_request(1'b1, ENT_SPEAKER, CTRL_VOLUME, REQ_GET_RES, 16'd2, 16'h0000);
    send_request(1'b1, ENT_MIC, CTRL_VOLUME, REQ_GET_RES, 16'd2, 16'h0000);
    send_request(1'b1, ENT_LINE, CTRL_VOLUME, REQ_GET_MIN, 16'd2, 16'h0000);
    send_request(1'b1, ENT_LINE, CTRL_VOLUME, REQ_GET_MAX, 16'd2, 16'h0000);
    // nonzero and zero mute bytes, each followed by a mute read with odd code and length
    send_request(1'b0, ENT_SPEAKER, CTRL_MUTE, REQ_SET_CUR, 16'd1, 16'h0080);
    send_request(1'b1, ENT_SPEAKER, CTRL_MUTE, 8'hff, 16'hffff, 16'h0000);
    send_request(1'b0, ENT_MIC, CTRL_MUTE, REQ_SET_CUR, 16'd1, 16'hff00);
    send_request(1'b1, ENT_MIC, CTRL_MUTE, 8'h00, 16'h0000, 16'h0000);
    // clamping on both ends and mid-range set
    send_request(1'b0, ENT_SPEAKER, CTRL_VOLUME, REQ_SET_CUR, 16'd2, 16'h8000);
    send_request(1'b1, ENT_SPEAKER, CTRL_VOLUME, REQ_GET_CUR, 16'd2, 16'h0000);
    send_request(1'b0, ENT_MIC, CTRL_VOLUME, REQ_SET_CUR, 16'd2, 16'h7fff);
    send_request(1'b0, ENT_LINE, CTRL_VOLUME, REQ_SET_CUR, 16'd2, 16'h1800);
    send_request(1'b1, ENT_LINE, CTRL_VOLUME, REQ_GET_CUR, 16'd2, 16'h0000);
    send_request(1'b0, ENT_SPEAKER, CTRL_VOLUME, REQ_SET_CUR, 16'd2, 16'hffff);
    send_request(1'b1, ENT_SPEAKER, CTRL_VOLUME, REQ_GET_CUR, 16'd2, 16'h0000);
    // stalls: rejected requests with an unknown entity, selector, request code or length
    send_request(1'b1, 8'h00, CTRL_MUTE, REQ_GET_CUR, 16'd1, 16'h0000);
    send_request(1'b0, 8'hff, CTRL_VOLUME, REQ_SET_CUR, 16'd2, 16'h1234);
    send_request(1'b1, ENT_MIC, 8'h00, REQ_GET_CUR, 16'd2, 16'h0000);
    send_request(1'b0, ENT_LINE, 8'hff, REQ_SET_CUR, 16'd2, 16'h0100);
    send_request(1'b0, ENT_SPEAKER, CTRL_MUTE, REQ_GET_CUR, 16'd1, 16'h0001);
    send_request(1'b0, ENT_MIC, CTRL_VOLUME, REQ_SET_CUR, 16'hffff, 16'h0100);
    send_request(1'b1, ENT_LINE, CTRL_VOLUME, 8'h00, 16'd2, 16'h0000);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 76 : 0;
      recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 21 : 0;
      for (int n = 0; n < 200; n++) begin
        if (phase == 0 && n == 100) begin
          s_valid <= 1'b0;
          while (tracker.pending() != 0) @(posedge clk_i);
        end
        send_random();
      end
    end

    s_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("checked %0d replies (%0d handled, %0d stalled) over three channels",
             tracker.handled + tracker.stalled, tracker.handled, tracker.stalled);
    $display("covered mute and volume sets and gets, clamping and stalls, three idle mixes");
    if (tracker.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule

// File: audio_feature_unit_control_core.f
sv/afu_pkg.sv
sv/afu_controller.sv
sv/afu_datapath.sv
sv/audio_feature_unit_control_core.sv
tb/testbench.sv
